// File: rtl/core/sfdw_pkg.sv
// shared types, command codes, bus constants and font table of the display writer
`timescale 1ns / 1ps
`default_nettype none
package sfdw_pkg;

	typedef enum logic [2:0] {
		OP_CHAR   = 3'd0,
		OP_CURSOR = 3'd1,
		OP_BRIGHT = 3'd2,
		OP_LED    = 3'd3,
		OP_INIT   = 3'd4
	} op_t;

	localparam logic [7:0] DEV_ID      = 8'hA0;
	localparam logic [7:0] CMD_ON_BASE = 8'h90;
	localparam logic [7:0] CMD_OFF     = 8'h80;
	localparam logic [7:0] BRIGHT_MASK = 8'h0F;
	localparam logic [7:0] CMD_ADDR    = 8'hC0;
	localparam logic [7:0] CMD_LED     = 8'h41;
	localparam logic [7:0] CURSOR_MAX  = 8'h21;
	localparam logic [7:0] CURSOR_STEP = 8'h03;
	localparam logic [7:0] SEG_BLANK   = 8'hFF;
	localparam int         MAX_BYTES   = 5;
	localparam int         CNT_W       = $clog2(MAX_BYTES + 1);

	typedef struct packed {
		logic [7:0] s1;
		logic [7:0] s0;
	} glyph_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] value;
		logic [7:0] cur;
	} cmd_t;

	function automatic glyph_t font_lookup(input logic [7:0] code);
		logic [7:0] ch;
		glyph_t     g;
		ch = code;
		if (code >= 8'h61 && code <= 8'h7A) begin
			ch = code - 8'h20;
		end
		case (ch)
			8'h20: g = '{s0: 8'h00, s1: 8'h00};
			8'h27: g = '{s0: 8'h00, s1: 8'h01};
			8'h2B: g = '{s0: 8'h40, s1: 8'hD5};
			8'h2C: g = '{s0: 8'h00, s1: 8'h10};
			8'h2D: g = '{s0: 8'h40, s1: 8'h84};
			8'h2E: g = '{s0: 8'h00, s1: 8'h80};
			8'h30: g = '{s0: 8'h3F, s1: 8'h00};
			8'h31: g = '{s0: 8'h30, s1: 8'h00};
			8'h32: g = '{s0: 8'h6D, s1: 8'h84};
			8'h33: g = '{s0: 8'h79, s1: 8'h84};
			8'h34: g = '{s0: 8'h72, s1: 8'h84};
			8'h35: g = '{s0: 8'h5B, s1: 8'h84};
			8'h36: g = '{s0: 8'h5F, s1: 8'h84};
			8'h37: g = '{s0: 8'h31, s1: 8'h00};
			8'h38: g = '{s0: 8'h7F, s1: 8'h84};
			8'h39: g = '{s0: 8'h7B, s1: 8'h84};
			8'h3A: g = '{s0: 8'h00, s1: 8'h40};
			8'h3D: g = '{s0: 8'h48, s1: 8'h84};
			8'h41: g = '{s0: 8'h77, s1: 8'h84};
			8'h42: g = '{s0: 8'h79, s1: 8'h8A};
			8'h43: g = '{s0: 8'h0F, s1: 8'h00};
			8'h44: g = '{s0: 8'h39, s1: 8'h0A};
			8'h45: g = '{s0: 8'h4F, s1: 8'h84};
			8'h46: g = '{s0: 8'h47, s1: 8'h84};
			8'h47: g = '{s0: 8'h5F, s1: 8'h00};
			8'h48: g = '{s0: 8'h76, s1: 8'h84};
			8'h49: g = '{s0: 8'h00, s1: 8'hD1};
			8'h4A: g = '{s0: 8'h3C, s1: 8'h00};
			8'h4B: g = '{s0: 8'hD6, s1: 8'h84};
			8'h4C: g = '{s0: 8'h0E, s1: 8'h00};
			8'h4D: g = '{s0: 8'hB6, s1: 8'h82};
			8'h4E: g = '{s0: 8'h36, s1: 8'hA2};
			8'h4F: g = '{s0: 8'h8F, s1: 8'h20};
			8'h50: g = '{s0: 8'h67, s1: 8'h84};
			8'h51: g = '{s0: 8'h8F, s1: 8'h30};
			8'h52: g = '{s0: 8'h67, s1: 8'hA4};
			8'h53: g = '{s0: 8'h0B, s1: 8'hA4};
			8'h54: g = '{s0: 8'h01, s1: 8'hD1};
			8'h55: g = '{s0: 8'h3E, s1: 8'h00};
			8'h56: g = '{s0: 8'h2E, s1: 8'h20};
			8'h57: g = '{s0: 8'h36, s1: 8'hA8};
			8'h58: g = '{s0: 8'h80, s1: 8'hAA};
			8'h59: g = '{s0: 8'h62, s1: 8'hD4};
			8'h5A: g = '{s0: 8'h89, s1: 8'h88};
			8'h5F: g = '{s0: 8'h08, s1: 8'h00};
			default: g = '{s0: SEG_BLANK, s1: SEG_BLANK};
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sfdw_font_rom.sv
// synchronous font rom, one registered read per cycle while rd_en is high
`timescale 1ns / 1ps
`default_nettype none
module sfdw_font_rom
	import sfdw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   rd_en,
	input  wire logic [7:0] rd_addr,
	output glyph_t      rd_data
);

	glyph_t data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= font_lookup(rd_addr);
		end
	end

	assign rd_data = data_q;

endmodule
`default_nettype wire

// File: rtl/core/sfdw_emitter.sv
// byte sequencer: builds one transaction and shifts it out a word per cycle while m_tready is high
`timescale 1ns / 1ps
`default_nettype none
module sfdw_emitter
	import sfdw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   ld_valid,
	output logic        ld_ready,
	input  cmd_t        ld_cmd,
	input  glyph_t      ld_glyph,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic             valid_q;
	logic [CNT_W-1:0] rem_q;
	logic             first_q;
	logic [7:0]       bytes_q [MAX_BYTES];

	logic             take;
	logic             load;
	logic [CNT_W-1:0] n_new;
	logic [7:0]       b_new [MAX_BYTES];
	logic [7:0]       bright;

	assign take     = valid_q && m_tready;
	assign ld_ready = !valid_q || (m_tready && rem_q == CNT_W'(1));
	assign load     = ld_valid && ld_ready;

	assign bright = (ld_cmd.value == 8'h00) ? CMD_OFF
		: ((ld_cmd.value & BRIGHT_MASK) + CMD_ON_BASE);

	always_comb begin
		n_new = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			b_new[i] = 8'h00;
		end
		b_new[0] = DEV_ID;
		unique case (ld_cmd.op)
			OP_CHAR: begin
				n_new    = CNT_W'(5);
				b_new[1] = CMD_ADDR | ld_cmd.cur;
				b_new[2] = ld_glyph.s0;
				b_new[3] = ld_glyph.s1;
			end
			OP_BRIGHT: begin
				n_new    = CNT_W'(2);
				b_new[1] = bright;
			end
			OP_LED: begin
				n_new    = CNT_W'(3);
				b_new[1] = CMD_LED;
				b_new[2] = ld_cmd.value;
			end
			OP_INIT: begin
				n_new    = CNT_W'(2);
				b_new[1] = CMD_ON_BASE;
			end
			default: begin
				n_new = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
			first_q <= 1'b0;
		end else if (load) begin
			valid_q <= (n_new != '0);
			rem_q   <= n_new;
			first_q <= 1'b1;
		end else if (take) begin
			valid_q <= (rem_q != CNT_W'(1));
			rem_q   <= rem_q - CNT_W'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= b_new;
		end else if (take) begin
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
			bytes_q[MAX_BYTES-1] <= 8'h00;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = bytes_q[0];
	assign m_tuser  = first_q;
	assign m_tlast  = (rem_q == CNT_W'(1));

endmodule
`default_nettype wire

// File: rtl/core/segment_font_display_writer.sv
// top level of the segment font display writer
// Each command word turns into one bus transaction of bus bytes, one output word per cycle while
// m_tready is high: a character is 5 bytes, brightness and init 2, leds 3, a cursor load or an
// unknown op emits nothing but still passes through the output byte sequencer. The output byte
// sequencer sets the rate; the next command is taken in while the current transaction is still
// shifting out, and the font rom read and cursor update happen on acceptance. An accepted
// command is registered with its glyph, then loaded into the sequencer's byte registers,
// from which its first byte is driven.
`timescale 1ns / 1ps
`default_nettype none
module segment_font_display_writer
	import sfdw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // op[2:0], value[10:3], zero[15:11]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // bus_byte[7:0]
	output logic             m_tuser,  // first[0]
	output logic             m_tlast
);

	logic       cmd_valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] cursor_q;
	logic       accept;
	logic       ld_ready;
	logic [2:0] in_op;
	logic [7:0] in_value;
	logic [7:0] cur_eff;
	glyph_t     glyph;

	assign in_op    = s_tdata[2:0];
	assign in_value = s_tdata[10:3];
	assign s_tready = !cmd_valid_s1 || ld_ready;
	assign accept   = s_tvalid && s_tready;
	assign cur_eff  = (cursor_q > CURSOR_MAX) ? 8'h00 : cursor_q;

	sfdw_font_rom u_font (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_value),
		.rd_data (glyph)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= 8'h00;
			cmd_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				cmd_valid_s1 <= 1'b1;
				case (in_op)
					OP_CHAR:   cursor_q <= cur_eff + CURSOR_STEP;
					OP_CURSOR: cursor_q <= in_value;
					OP_INIT:   cursor_q <= 8'h00;
					default:   cursor_q <= cursor_q;
				endcase
			end else if (ld_ready) begin
				cmd_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op    <= in_op;
			cmd_s1.value <= in_value;
			cmd_s1.cur   <= cur_eff;
		end
	end

	sfdw_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (cmd_valid_s1),
		.ld_ready (ld_ready),
		.ld_cmd   (cmd_s1),
		.ld_glyph (glyph),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: rtl/core/sfdw_checker.sv
// port-level checker for the display writer and its bind
`timescale 1ns / 1ps
`default_nettype none
module sfdw_checker
	import sfdw_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser,
	input wire logic       m_tlast
);

	logic in_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			in_frame_q <= !m_tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_start_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == DEV_ID)
		else $error("transaction does not open with device id");

	a_no_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tlast))
		else $error("one-byte transaction");

	a_framing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == !in_frame_q))
		else $error("start flag out of place");

endmodule

bind segment_font_display_writer sfdw_checker u_sfdw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
